FILE: rtl/core/bpfc_pkg.sv
// Shared types and constants of the beacon packet framer.
`default_nettype none
package bpfc_pkg;

   localparam int unsigned NUM_COORDS  = 6;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned POS_W       = 6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PREAMBLE_PAIRS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BEACON1_X      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BEACON3_Y      = 3'd6;

   // Reset values
   localparam logic [3:0]  PAIRS_RESET = 4'd4;
   localparam logic [15:0] B1X_RESET   = 16'd0;
   localparam logic [15:0] B1Y_RESET   = 16'd0;
   localparam logic [15:0] B2X_RESET   = 16'd496;
   localparam logic [15:0] B2Y_RESET   = 16'd0;
   localparam logic [15:0] B3X_RESET   = 16'd496;
   localparam logic [15:0] B3Y_RESET   = 16'd240;

   // Frame bytes after the preamble, by position within that part
   localparam logic [7:0] SYNC_0      = 8'h41;
   localparam logic [7:0] SYNC_1      = 8'h42;
   localparam logic [7:0] SYNC_2      = 8'h43;
   localparam logic [7:0] SYNC_3      = 8'h44;
   localparam logic [7:0] SYNC_4      = 8'hC0;
   localparam logic [7:0] LENGTH_BYTE = 8'd13;
   localparam logic [7:0] TRAIN_LO    = 8'h00;
   localparam logic [7:0] TRAIN_HI    = 8'hFF;

   localparam logic [POS_W-1:0] IDX_LENGTH   = 6'd5;
   localparam logic [POS_W-1:0] IDX_PAY_FST  = 6'd6;
   localparam logic [POS_W-1:0] IDX_PAY_LST  = 6'd17;
   localparam logic [POS_W-1:0] IDX_CSUM_HI  = 6'd18;

   typedef struct packed {
      logic [3:0]                       pairs;
      logic [NUM_COORDS-1:0][15:0]      coords;
      logic [15:0]                      csum;
   } cfg_type;

   // Payload word of one coordinate: each byte plus one, modulo 256
   function automatic logic [15:0] payload_word(input logic [15:0] c);
      payload_word = {c[15:8] + 8'd1, c[7:0] + 8'd1};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bpfc_csr.sv
// Configuration registers and registered payload checksum.
`default_nettype none
module bpfc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [bpfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bpfc_pkg::CSR_DATA_W-1:0] csr_data,
   output bpfc_pkg::cfg_type                    cfg
);
   import bpfc_pkg::*;

   logic [3:0]                  pairs_ff;
   logic [NUM_COORDS-1:0][15:0] coords_ff;
   logic [15:0]                 csum_ff;
   logic [15:0]                 csum_in;
   logic [18:0]                 acc;
   logic [16:0]                 fold1;
   logic [15:0]                 fold2;

   always_comb begin
      acc = '0;
      for (int k = 0; k < NUM_COORDS; k++) begin
         acc = acc + {3'b000, payload_word(coords_ff[k])};
      end
      fold1   = {1'b0, acc[15:0]} + {14'd0, acc[18:16]};
      // second fold cannot carry again
      fold2   = fold1[15:0] + {15'd0, fold1[16]};
      csum_in = ~fold2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_ff     <= PAIRS_RESET;
         coords_ff[0] <= B1X_RESET;
         coords_ff[1] <= B1Y_RESET;
         coords_ff[2] <= B2X_RESET;
         coords_ff[3] <= B2Y_RESET;
         coords_ff[4] <= B3X_RESET;
         coords_ff[5] <= B3Y_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_PREAMBLE_PAIRS) begin
            pairs_ff <= csr_data[3:0];
         end else if (csr_index >= REG_BEACON1_X && csr_index <= REG_BEACON3_Y) begin
            coords_ff[csr_index - REG_BEACON1_X] <= csr_data;
         end
      end
   end

   // Checksum register follows the coordinates in the cycle after they change
   always_ff @(posedge clock) begin
      csum_ff <= csum_in;
   end

   assign cfg.pairs  = pairs_ff;
   assign cfg.coords = coords_ff;
   assign cfg.csum   = csum_ff;

endmodule
`default_nettype wire

FILE: rtl/core/bpfc_seq.sv
// Frame byte sequencer with request hold register and output register.
`default_nettype none
module bpfc_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  bpfc_pkg::cfg_type      cfg,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic              req_send,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_byte,
   output logic                   rsp_last
);
   import bpfc_pkg::*;

   logic             pend_ff, pend_in;
   logic             active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             oval_ff, oval_in;
   logic [7:0]       obyte_ff, obyte_in;
   logic             olast_ff, olast_in;

   logic             advance;
   logic [POS_W-1:0] pre_len;
   logic [POS_W-1:0] idx;
   logic [POS_W-1:0] pidx;
   logic [15:0]      word;
   logic [7:0]       cur_byte;
   logic             cur_last;

   assign req_tready = !pend_ff;
   assign advance    = !oval_ff || rsp_tready;
   assign pre_len    = {1'b0, cfg.pairs, 1'b0};
   assign idx        = pos_ff - pre_len;
   assign pidx       = idx - IDX_PAY_FST;
   assign word       = payload_word(cfg.coords[pidx[3:1]]);

   always_comb begin
      cur_last = 1'b0;
      if (pos_ff < pre_len) begin
         cur_byte = pos_ff[0] ? TRAIN_HI : TRAIN_LO;
      end else begin
         case (idx) inside
            6'd0:                     cur_byte = SYNC_0;
            6'd1:                     cur_byte = SYNC_1;
            6'd2:                     cur_byte = SYNC_2;
            6'd3:                     cur_byte = SYNC_3;
            6'd4:                     cur_byte = SYNC_4;
            IDX_LENGTH:               cur_byte = LENGTH_BYTE;
            [IDX_PAY_FST:IDX_PAY_LST]: cur_byte = pidx[0] ? word[7:0] : word[15:8];
            IDX_CSUM_HI:              cur_byte = cfg.csum[15:8];
            default: begin
               cur_byte = cfg.csum[7:0];
               cur_last = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      pend_in   = pend_ff;
      active_in = active_ff;
      pos_in    = pos_ff;
      oval_in   = oval_ff;
      obyte_in  = obyte_ff;
      olast_in  = olast_ff;
      // hold a request only when it asks for a frame
      if (req_tvalid && req_tready && req_send) begin
         pend_in = 1'b1;
      end
      if (!active_ff && pend_ff) begin
         pend_in   = 1'b0;
         active_in = 1'b1;
         pos_in    = '0;
      end
      if (advance) begin
         oval_in = active_ff;
         if (active_ff) begin
            obyte_in = cur_byte;
            olast_in = cur_last;
            pos_in   = pos_ff + 6'd1;
            if (cur_last) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         active_ff <= 1'b0;
         pos_ff    <= '0;
         oval_ff   <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         active_ff <= active_in;
         pos_ff    <= pos_in;
         oval_ff   <= oval_in;
      end
   end

   always_ff @(posedge clock) begin
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = oval_ff;
   assign rsp_byte   = obyte_ff;
   assign rsp_last   = olast_ff;

endmodule
`default_nettype wire

FILE: rtl/core/beacon_packet_framer_checksum_top.sv
// Top level of the beacon packet framer with ones'-complement checksum.
//
//  channel | direction | handshake              | payload
//  req_    | in        | req_tvalid/req_tready  | tdata[0] send_request
//  rsp_    | out       | rsp_tvalid/rsp_tready  | tdata tx_byte, tlast frame_end
//  csr_    | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// A frame of 2*preamble_pairs + 20 bytes leaves at one byte per cycle while
// rsp_tready stays high; a taken request is held, then starts the sequencer,
// and the first byte comes from the output register. Frames are parted by idle
// output while the sequencer restarts, unless rsp_tready was low. One further
// request is held while a frame is sent; req_tready drops until it starts.
// Requests with send_request low are dropped. Reset is synchronous and restores
// the register defaults; the checksum register settles the cycle after a write.
`default_nettype none
module beacon_packet_framer_checksum_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [0] send_request
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [7:0] tx_byte
   output logic                                 rsp_tlast,   // frame_end
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bpfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bpfc_pkg::CSR_DATA_W-1:0] csr_data
);
   import bpfc_pkg::*;

   cfg_type cfg;

   assign csr_ready = 1'b1;

   bpfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bpfc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_send   (req_tdata[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: rtl/core/bpfc_checker.sv
// Port-level checks of the beacon packet framer, bound to the top level.
`default_nettype none
module bpfc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);
   logic [5:0] cnt_ff;

   // count byte transfers since the last frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         cnt_ff <= rsp_tlast ? 6'd0 : cnt_ff + 6'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not idle after reset");

   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tdata[0]))
      else $error("req_tready dropped without a frame request");

   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && cnt_ff == 6'd49 |-> rsp_tlast)
      else $error("frame longer than fifty bytes");

endmodule

bind beacon_packet_framer_checksum_top bpfc_checker u_bpfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
